// ===== rtl/lfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsc_pkg
// Shared widths and codes of the log-frequency spectrum column core.
// ----------------------------------------------------------------------------
package lfsc_pkg;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 64;
  localparam int TERM_W = 12;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [7:0] CFG_ROW_RATIO = 8'd0;
  localparam logic [7:0] CFG_BIN_SCALE = 8'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic [30:0] ROW_RATIO_RESET = 31'd1085434120;
  localparam logic [31:0] BIN_SCALE_RESET = 32'd8421504;
  localparam logic [31:0] X_ONE           = 32'h0010_0000;

endpackage

// ===== rtl/lfsc_item_if.sv =====
// ----------------------------------------------------------------------------
// lfsc_item_if
// Input channel: load or emit commands with bin payload.
// ----------------------------------------------------------------------------
interface lfsc_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [9:0]  bin_index;
  logic [23:0] bin_level;
  modport source (output valid, command, bin_index, bin_level, input ready);
  modport sink   (input valid, command, bin_index, bin_level, output ready);
endinterface

// ===== rtl/lfsc_row_if.sv =====
// ----------------------------------------------------------------------------
// lfsc_row_if
// Output channel: one display row per transaction.
// ----------------------------------------------------------------------------
interface lfsc_row_if;
  logic        valid;
  logic        ready;
  logic [8:0]  screen_line;
  logic [14:0] color_index;
  logic        last;
  modport source (output valid, screen_line, color_index, last, input ready);
  modport sink   (input valid, screen_line, color_index, last, output ready);
endinterface

// ===== rtl/lfsc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lfsc_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface lfsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/log_frequency_spectrum_column_core.sv =====
// ----------------------------------------------------------------------------
// log_frequency_spectrum_column_core
// Loads spectrum bins and emits one log-spaced display row per emit command.
//
//   channel | modport | transaction
//   items   | sink    | load one bin or emit the next row
//   rows    | source  | screen line, color index, last flag
//   cfg     | sink    | register write (0 row_ratio, 1 bin_scale)
//
// Load: one bin written from idle. Edge rows: one bin read and clamped.
// Middle rows: the products, the bin read loop, the one-bit-per-cycle divider.
// Reset is synchronous; the bin store holds no reset and must be loaded.
// A finished row waits in the output register; a next emit stalls at its end
// while that register is still full.
// ----------------------------------------------------------------------------
module log_frequency_spectrum_column_core #(
  parameter int FFT_SIZE = 1024,
  parameter int ROWS     = 512,
  parameter int COLORS   = 32768
) (
  input logic       clk,
  input logic       rst,
  lfsc_item_if.sink items,
  lfsc_row_if.source rows,
  lfsc_cfg_if.sink  cfg
);

  localparam int BIN_TOP = FFT_SIZE / 2;
  localparam int AW      = $clog2(BIN_TOP + 1);
  localparam int KW      = $clog2(BIN_TOP + 3) + 1;
  localparam int RW      = $clog2(ROWS);
  localparam int MW      = lfsc_pkg::MUL_W;
  localparam logic [41:0] BP_MAX = 42'(BIN_TOP) << 16;
  localparam logic [39:0] COLOR_MAX = 40'(COLORS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE_RD, S_EDGE_GET, S_MUL_P, S_SAT_P, S_MUL_B, S_SAT_B,
    S_RD_A, S_RD_B, S_TERM_MUL, S_TERM_ACC, S_DIV_START, S_DIV_WAIT, S_OUT
  } state_t;

  state_t state;
  logic [30:0] row_ratio;
  logic [31:0] bin_scale;
  logic [RW-1:0] row_count;
  logic [31:0] power_acc;
  logic [31:0] prev_breakpoint;
  logic [31:0] xm1;
  logic [31:0] tx;
  logic [KW-1:0] k;
  logic [23:0] a_reg;
  logic [23:0] b_reg;
  logic signed [lfsc_pkg::SUM_W-1:0] sum;
  logic [lfsc_pkg::TERM_W-1:0] terms;
  logic [AW-1:0] edge_addr;
  logic [15:0] res_color;
  logic res_last;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [lfsc_pkg::PROD_W-1:0] prod;
  logic [23:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [KW-1:0] k_sel;
  logic mem_we;
  logic [lfsc_pkg::SUM_W-1:0] quot;
  logic div_start;
  logic div_done;

  logic [37:0] p_hi;
  logic [31:0] p_sat;
  logic [41:0] bp_raw;
  logic [31:0] bp_clamped;
  logic [KW-1:0] k_next;
  logic signed [MW-1:0] frac;
  logic signed [MW-1:0] diff;
  logic [15:0] edge_level;
  logic [39:0] q_int;

  assign items.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  assign mem_we = items.valid && items.ready && (items.command == lfsc_pkg::CMD_LOAD) &&
                  ({22'b0, items.bin_index} <= 32'(BIN_TOP));

  always_comb begin
    case (state)
      S_RD_A:     k_sel = k;
      S_RD_B:     k_sel = k + KW'(1);
      S_TERM_ACC: k_sel = k + KW'(2);
      default:    k_sel = '0;
    endcase
    if (state == S_EDGE_RD) begin
      rd_addr = edge_addr;
    end else if (k_sel > KW'(BIN_TOP)) begin
      rd_addr = AW'(BIN_TOP);
    end else begin
      rd_addr = k_sel[AW-1:0];
    end
  end

  lfsc_bin_mem #(.DEPTH(BIN_TOP + 1), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(items.bin_index)),
    .wdata (items.bin_level),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign frac = $signed({2'b0, tx}) - $signed(MW'({k, 16'b0}));
  assign diff = $signed(MW'(rd_data)) - $signed(MW'(a_reg));

  always_comb begin
    case (state)
      S_MUL_P: begin
        mul_a = $signed(MW'(power_acc));
        mul_b = $signed(MW'(row_ratio));
      end
      S_MUL_B: begin
        mul_a = $signed(MW'(xm1));
        mul_b = $signed(MW'(bin_scale));
      end
      S_TERM_MUL: begin
        mul_a = frac;
        mul_b = diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lfsc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  assign div_start = (state == S_DIV_START) && (sum > 0);

  lfsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (terms),
    .done     (div_done),
    .quot     (quot)
  );

  assign p_hi       = prod[67:30];
  assign p_sat      = (p_hi[37:32] != '0) ? 32'hFFFF_FFFF : p_hi[31:0];
  assign bp_raw     = prod[67:26];
  assign bp_clamped = (bp_raw > BP_MAX) ? BP_MAX[31:0] : bp_raw[31:0];
  assign k_next     = k + KW'(1);
  assign edge_level = rd_data[23:8];
  assign q_int      = quot[63:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      row_ratio       <= lfsc_pkg::ROW_RATIO_RESET;
      bin_scale       <= lfsc_pkg::BIN_SCALE_RESET;
      row_count       <= '0;
      power_acc       <= lfsc_pkg::X_ONE;
      prev_breakpoint <= '0;
      rows.valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == lfsc_pkg::CFG_ROW_RATIO) begin
          row_ratio <= cfg.data[30:0];
        end else if (cfg.index == lfsc_pkg::CFG_BIN_SCALE) begin
          bin_scale <= cfg.data;
        end
      end
      if (rows.valid && rows.ready && state != S_OUT) begin
        rows.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (items.valid && items.command == lfsc_pkg::CMD_EMIT) begin
            res_last <= (row_count == RW'(ROWS - 1));
            if (row_count == '0) begin
              edge_addr <= '0;
              state     <= S_EDGE_RD;
            end else if (row_count == RW'(ROWS - 1)) begin
              edge_addr <= AW'(BIN_TOP - 1);
              state     <= S_EDGE_RD;
            end else begin
              state <= S_MUL_P;
            end
          end
        end
        S_EDGE_RD: state <= S_EDGE_GET;
        S_EDGE_GET: begin
          res_color <= ({1'b0, edge_level} >= 17'(COLORS)) ? 16'(COLORS - 1) : edge_level;
          state     <= S_OUT;
        end
        S_MUL_P: state <= S_SAT_P;
        S_SAT_P: begin
          power_acc <= p_sat;
          xm1       <= (p_sat > lfsc_pkg::X_ONE) ? p_sat - lfsc_pkg::X_ONE : '0;
          state     <= S_MUL_B;
        end
        S_MUL_B: state <= S_SAT_B;
        S_SAT_B: begin
          tx              <= bp_clamped;
          k               <= KW'(prev_breakpoint[31:16]);
          prev_breakpoint <= bp_clamped;
          sum             <= '0;
          terms           <= '0;
          state           <= S_RD_A;
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          a_reg <= rd_data;
          state <= S_TERM_MUL;
        end
        S_TERM_MUL: begin
          b_reg <= rd_data;
          state <= S_TERM_ACC;
        end
        S_TERM_ACC: begin
          sum   <= sum + $signed({24'b0, a_reg, 16'b0}) + prod[63:0];
          terms <= terms + 1'b1;
          k     <= k_next;
          a_reg <= b_reg;
          if ({{(MW - KW - 16){1'b0}}, k_next, 16'b0} < {2'b0, tx}) begin
            state <= S_TERM_MUL;
          end else begin
            state <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          if (sum > 0) begin
            state <= S_DIV_WAIT;
          end else begin
            res_color <= '0;
            state     <= S_OUT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res_color <= (q_int > COLOR_MAX) ? COLOR_MAX[15:0] : q_int[15:0];
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rows.valid || rows.ready) begin
            rows.valid       <= 1'b1;
            rows.screen_line <= 9'(RW'(ROWS - 1) - row_count);
            rows.color_index <= res_color[14:0];
            rows.last        <= res_last;
            if (res_last) begin
              row_count       <= '0;
              power_acc       <= lfsc_pkg::X_ONE;
              prev_breakpoint <= '0;
            end else begin
              row_count <= row_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_top: assert property (@(posedge clk) disable iff (rst)
    rows.valid && rows.last |-> rows.screen_line == '0)
    else $error("last row not at top screen line");
  a_terms: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_WAIT |-> terms != '0)
    else $error("division with no terms");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_count <= RW'(ROWS - 1))
    else $error("row count out of range");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside wait");
`endif

endmodule

// ===== rtl/lfsc_bin_mem.sv =====
// ----------------------------------------------------------------------------
// lfsc_bin_mem
// Spectrum level store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfsc_bin_mem #(
  parameter int DEPTH = 513,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lfsc_mul.sv =====
// ----------------------------------------------------------------------------
// lfsc_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module lfsc_mul (
  input  logic                              clk,
  input  logic signed [lfsc_pkg::MUL_W-1:0]  a,
  input  logic signed [lfsc_pkg::MUL_W-1:0]  b,
  output logic signed [lfsc_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/lfsc_div.sv =====
// ----------------------------------------------------------------------------
// lfsc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfsc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lfsc_pkg::SUM_W-1:0]       dividend,
  input  logic [lfsc_pkg::TERM_W-1:0]      divisor,
  output logic                             done,
  output logic [lfsc_pkg::SUM_W-1:0]       quot
);

  logic                            busy;
  logic [lfsc_pkg::DIV_CNT_W-1:0]  cnt;
  logic [lfsc_pkg::TERM_W:0]       rem;
  logic [lfsc_pkg::TERM_W-1:0]     dsor;
  logic [lfsc_pkg::TERM_W+1:0]     rem_sh;
  logic [lfsc_pkg::TERM_W+1:0]     rem_sub;

  assign rem_sh  = {rem, quot[lfsc_pkg::SUM_W-1]};
  assign rem_sub = rem_sh - {2'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quot <= dividend;
        dsor <= divisor;
      end else if (busy) begin
        if (!rem_sub[lfsc_pkg::TERM_W+1]) begin
          rem  <= rem_sub[lfsc_pkg::TERM_W:0];
          quot <= {quot[lfsc_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[lfsc_pkg::TERM_W:0];
          quot <= {quot[lfsc_pkg::SUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == lfsc_pkg::DIV_CNT_W'(lfsc_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
